/* rtl/goq_pkg.sv */
// ----------------------------------------------------------------------------
// goq_pkg: shared types for the group ordered queue
// Command and status codes, controller states and the command struct that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package goq_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdW     = 16;
  localparam int unsigned GrpW    = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ENQ  = 2'd1,
    CMD_DEQ  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_QFULL   = 3'd2,
    ST_QEMPTY  = 3'd3,
    ST_TFULL   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_FIND  = 3'd1,
    S_MASK  = 3'd2,
    S_APPLY = 3'd3,
    S_OUT   = 3'd4
  } state_e;

  // Controller to datapath step strobes
  typedef struct packed {
    logic capture;
    logic find;
    logic mask;
    logic apply;
  } dp_cmd_t;

endpackage

/* rtl/goq_ctrl.sv */
// ----------------------------------------------------------------------------
// goq_ctrl: sequencing controller
// Walks one word through capture, table lookup, group mask and update, then
// holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module goq_ctrl
  import goq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_ready_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dp_cmd_t dp_cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_FIND;
      S_FIND:  state_d = S_MASK;
      S_MASK:  state_d = S_APPLY;
      S_APPLY: state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    out_valid_o      = (state_q == S_OUT);
    dp_cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    dp_cmd_o.find    = (state_q == S_FIND);
    dp_cmd_o.mask    = (state_q == S_MASK);
    dp_cmd_o.apply   = (state_q == S_APPLY);
  end

endmodule

/* rtl/goq_datapath.sv */
// ----------------------------------------------------------------------------
// goq_datapath: member table cells and queue slot cells
// Parallel compare cells find the member and the group run; the queue slots
// shift in place to open a gap or close the head.
// ----------------------------------------------------------------------------
module goq_datapath
  import goq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             dp_cmd_i,
  input  logic [CmdW-1:0]     command_i,
  input  logic [IdW-1:0]      member_id_i,
  input  logic [GrpW-1:0]     group_i,
  output logic [StatusW-1:0]  status_o,
  output logic [IdW-1:0]      removed_id_o,
  output logic [CountW-1:0]   queue_count_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = $clog2(TABLE_DEPTH + 1);

  // Captured word
  cmd_e            cmd_q;
  logic [IdW-1:0]  id_q;
  logic [GrpW-1:0] grp_q;

  // Lookup results
  logic            hit_q, hit_d;
  logic [GrpW-1:0] tgrp_q, tgrp_d;
  logic [QUEUE_DEPTH-1:0] m_q, m_d;

  // Stored state
  logic [IdW-1:0]  tab_id  [TABLE_DEPTH];
  logic [GrpW-1:0] tab_grp [TABLE_DEPTH];
  logic [TW-1:0]   tcnt_q;
  logic [IdW-1:0]  q_id  [QUEUE_DEPTH];
  logic [GrpW-1:0] q_grp [QUEUE_DEPTH];
  logic [QW-1:0]   qcnt_q;

  logic [StatusW-1:0] status_q, status_d;
  logic [IdW-1:0]     removed_q, removed_d;

  // Insert placement
  logic [QUEUE_DEPTH:0] above;
  logic [QUEUE_DEPTH:0] below;
  logic                 any_m;
  logic [QW+CountW-1:0] qc_wide;

  // Table lookup: ids are unique in the table, so an OR of matches suffices
  always_comb begin
    hit_d  = 1'b0;
    tgrp_d = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if ((TW'(k) < tcnt_q) && (tab_id[k] == id_q)) begin
        hit_d  = 1'b1;
        tgrp_d = tgrp_d | tab_grp[k];
      end
    end
  end

  // Group mask over occupied slots
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      m_d[k] = (QW'(k) < qcnt_q) && (q_grp[k] == tgrp_q);
    end
  end

  // above[k]: some group member at slot k or later
  always_comb begin
    above[QUEUE_DEPTH] = 1'b0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      above[k] = above[k+1] | m_q[k];
    end
    below = {above[QUEUE_DEPTH-1:0], 1'b1};
    any_m = above[0];
  end

  // Result status and removed id
  always_comb begin
    status_d  = ST_OK;
    removed_d = '0;
    unique case (cmd_q)
      CMD_LOAD: if (!hit_q && (tcnt_q == TW'(TABLE_DEPTH))) status_d = ST_TFULL;
      CMD_ENQ: begin
        if (!hit_q) status_d = ST_UNKNOWN;
        else if (qcnt_q == QW'(QUEUE_DEPTH)) status_d = ST_QFULL;
      end
      CMD_DEQ: begin
        if (qcnt_q == '0) status_d = ST_QEMPTY;
        else removed_d = q_id[0];
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q <= '0;
      qcnt_q <= '0;
    end else if (dp_cmd_i.apply) begin
      unique case (cmd_q)
        CMD_LOAD: if (!hit_q && (tcnt_q != TW'(TABLE_DEPTH))) tcnt_q <= tcnt_q + 1'b1;
        CMD_ENQ:  if (hit_q && (qcnt_q != QW'(QUEUE_DEPTH))) qcnt_q <= qcnt_q + 1'b1;
        CMD_DEQ:  if (qcnt_q != '0) qcnt_q <= qcnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Payload: captured word, lookups, result
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= member_id_i;
      grp_q <= group_i;
    end
    if (dp_cmd_i.find) begin
      hit_q  <= hit_d;
      tgrp_q <= tgrp_d;
    end
    if (dp_cmd_i.mask) begin
      m_q <= m_d;
    end
    if (dp_cmd_i.apply) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  // Member table cells
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.apply && (cmd_q == CMD_LOAD) && !hit_q) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (TW'(k) == tcnt_q) begin
          tab_id[k]  <= id_q;
          tab_grp[k] <= grp_q;
        end
      end
    end
  end

  // Queue slot cells
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.apply) begin
      if ((cmd_q == CMD_ENQ) && hit_q && (qcnt_q != QW'(QUEUE_DEPTH))) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
          if (any_m ? (below[k] && !above[k]) : (QW'(k) == qcnt_q)) begin
            q_id[k]  <= id_q;
            q_grp[k] <= tgrp_q;
          end else if (k > 0 && any_m && !below[k] && (QW'(k) <= qcnt_q)) begin
            q_id[k]  <= q_id[(k > 0) ? k - 1 : 0];
            q_grp[k] <= q_grp[(k > 0) ? k - 1 : 0];
          end
        end
      end else if ((cmd_q == CMD_DEQ) && (qcnt_q != '0)) begin
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
          q_id[k]  <= q_id[k+1];
          q_grp[k] <= q_grp[k+1];
        end
      end
    end
  end

  // Result
  assign qc_wide       = (QW+CountW)'(qcnt_q);
  assign status_o      = status_q;
  assign removed_id_o  = removed_q;
  assign queue_count_o = qc_wide[CountW-1:0];

endmodule

/* rtl/group_ordered_queue_top.sv */
// ----------------------------------------------------------------------------
// group_ordered_queue_top: team queue with a member to group table
// Stream in, stream out; one result word per command word.
// ----------------------------------------------------------------------------
// A command word is captured at acceptance, then passes in turn through the
// table lookup across all member cells, the group compare across all queue
// slots and the in-place shift update of the slots, after which its result
// word is offered. The next word is taken only in the cycle after the result
// has been accepted, so no word is taken while another is in flight, and a
// stall on the output side holds off the input too. Load adds a member
// (duplicates are ignored), enqueue places a member behind the last queued
// member of its group or at the tail, dequeue returns the head. Misses, full
// and empty cases are reported in status and change nothing. No clearing pass
// is run after reset.
module group_ordered_queue_top
  import goq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] command, [17:2] member_id, [25:18] group, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] status, [18:3] removed_id, [25:19] queue_count, rest zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  dp_cmd_t            dp_cmd;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     removed_id;
  logic [CountW-1:0]  queue_count;

  goq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .dp_cmd_o    (dp_cmd)
  );

  goq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .command_i     (s_axis_tdata[1:0]),
    .member_id_i   (s_axis_tdata[17:2]),
    .group_i       (s_axis_tdata[25:18]),
    .status_o      (status),
    .removed_id_o  (removed_id),
    .queue_count_o (queue_count)
  );

  assign m_axis_tdata = {6'b0, queue_count, removed_id, status};

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken during processing");

  a_removed_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK)) |-> (m_axis_tdata[18:3] == '0))
    else $error("removed id set on a failed command");

  a_result_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##3 m_axis_tvalid)
    else $error("result not presented after update");

endmodule
